@@ design/lpht_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared constants, codes and controller/datapath interface types for the
// linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int TABLE_SLOTS_DEF = 32;
  localparam int VALUE_BITS_DEF  = 32;

  localparam int KEY_BITS   = 31;
  localparam int MARK_BITS  = 2;
  localparam int OP_BITS    = 2;
  localparam int DATA_BITS  = 32;
  localparam int STAT_BITS  = 2;
  localparam int SLOT_BITS  = 5;

  localparam int S_DATA_BITS = 72;
  localparam int M_DATA_BITS = 40;

  // The home slot is found by long division of the key, one byte per cycle.
  localparam int HASH_CHUNK = 8;
  localparam int HASH_STEPS = (KEY_BITS + HASH_CHUNK - 1) / HASH_CHUNK;
  localparam int HASH_BITS  = HASH_STEPS * HASH_CHUNK;
  localparam int HC_BITS    = $clog2(HASH_STEPS);

  localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_BITS-1:0] OP_DELETE = 2'd2;

  localparam logic [MARK_BITS-1:0] MARK_EMPTY = 2'd0;
  localparam logic [MARK_BITS-1:0] MARK_USED  = 2'd1;
  localparam logic [MARK_BITS-1:0] MARK_GONE  = 2'd2;

  localparam logic [STAT_BITS-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_MISSING = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic clear;
    logic capture;
    logic hash_step;
    logic probe;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic hash_last;
    logic op_valid;
    logic decided;
  } sts_t;

endpackage
`default_nettype wire

@@ design/lpht_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ design/lpht_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_datapath
// Item registers, home-slot divider, probe address and counters, slot memory
// and result/output registers.
// ----------------------------------------------------------------------------
module lpht_datapath #(
  parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF,
  parameter int VALUE_BITS  = lpht_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lpht_pkg::cmd_t                 cmd,
  output lpht_pkg::sts_t                 sts,
  input  logic [lpht_pkg::OP_BITS-1:0]   operation,
  input  logic [lpht_pkg::KEY_BITS-1:0]  key,
  input  logic [lpht_pkg::DATA_BITS-1:0] value,
  output logic [lpht_pkg::STAT_BITS-1:0] status,
  output logic [lpht_pkg::DATA_BITS-1:0] value_out,
  output logic [lpht_pkg::SLOT_BITS-1:0] slot_index
);
  import lpht_pkg::*;

  localparam int IW        = $clog2(TABLE_SLOTS);
  localparam int CW        = $clog2(TABLE_SLOTS + 1);
  localparam int WORD_BITS = MARK_BITS + KEY_BITS + VALUE_BITS;

  localparam logic [IW:0]    SLOTS_W   = (IW + 1)'(TABLE_SLOTS);
  localparam logic [IW-1:0]  LAST_SLOT = IW'(TABLE_SLOTS - 1);
  localparam logic [CW-1:0]  SLOTS_C   = CW'(TABLE_SLOTS);
  localparam logic [CW-1:0]  LAST_C    = CW'(TABLE_SLOTS - 1);
  localparam logic [HC_BITS-1:0] HC_LAST = HC_BITS'(HASH_STEPS - 1);

  logic [OP_BITS-1:0]    op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [HASH_BITS-1:0]  key_sh;
  logic [HC_BITS-1:0]    hc;
  logic [IW-1:0]         rem;
  logic [IW-1:0]         rem_next;
  logic [IW-1:0]         rd_addr;
  logic [IW-1:0]         rd_addr_next;
  logic [CW-1:0]         issued;
  logic [CW-1:0]         evaluated;
  logic                  pend;
  logic [IW-1:0]         ev_addr;
  logic [IW-1:0]         clr_addr;
  logic [STAT_BITS-1:0]  res_status;
  logic [DATA_BITS-1:0]  res_value;
  logic [SLOT_BITS-1:0]  res_slot;

  logic [63:0]           value_wide;
  logic [63:0]           rd_val_wide;
  logic [31:0]           ev_wide;
  logic                  hash_last;
  logic                  rd_en;
  logic                  ev_ok;
  logic                  is_ins;
  logic                  is_look;
  logic                  is_del;
  logic                  key_hit;
  logic                  hit;
  logic                  stop;
  logic                  exhaust;
  logic                  we;
  logic [IW-1:0]         waddr;
  logic [WORD_BITS-1:0]  wdata;
  logic [WORD_BITS-1:0]  rd_data;
  logic [MARK_BITS-1:0]  rd_mark;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;

  assign value_wide  = 64'(value);
  assign rd_val_wide = 64'(rd_val);
  assign ev_wide     = 32'(ev_addr);

  // Eight steps of restoring division per cycle, most significant key bits first.
  always_comb begin
    logic [IW:0]   t;
    logic [IW-1:0] r;
    t = '0;
    r = rem;
    for (int i = 0; i < HASH_CHUNK; i++) begin
      t = {r, key_sh[HASH_BITS-1-i]};
      if (t >= SLOTS_W) begin
        t = t - SLOTS_W;
      end
      r = t[IW-1:0];
    end
    rem_next = r;
  end

  assign hash_last    = cmd.hash_step && (hc == HC_LAST);
  assign rd_addr_next = (rd_addr == LAST_SLOT) ? '0 : rd_addr + IW'(1);

  // Reads run one slot ahead of the evaluation of the previous slot's word.
  assign rd_en = cmd.probe && (issued != SLOTS_C);
  assign ev_ok = cmd.probe && pend;

  assign rd_mark = rd_data[MARK_BITS-1:0];
  assign rd_key  = rd_data[MARK_BITS +: KEY_BITS];
  assign rd_val  = rd_data[MARK_BITS + KEY_BITS +: VALUE_BITS];

  assign is_ins  = (op_r == OP_INSERT);
  assign is_look = (op_r == OP_LOOKUP);
  assign is_del  = (op_r == OP_DELETE);
  assign key_hit = (rd_mark == MARK_USED) && (rd_key == key_r);

  assign hit     = ev_ok && (is_ins ? (rd_mark != MARK_USED) : ((is_look || is_del) && key_hit));
  assign stop    = ev_ok && !is_ins && (rd_mark == MARK_EMPTY);
  assign exhaust = ev_ok && (evaluated == LAST_C);

  // A delete rewrites the slot with its own key and value and a tombstone mark.
  assign we    = cmd.clear || (hit && !is_look);
  assign waddr = cmd.clear ? clr_addr : ev_addr;
  always_comb begin
    if (cmd.clear) begin
      wdata = WORD_BITS'(MARK_EMPTY);
    end else if (is_ins) begin
      wdata = {val_r, key_r, MARK_USED};
    end else begin
      wdata = {rd_val, rd_key, MARK_GONE};
    end
  end

  lpht_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      hc        <= '0;
      rd_addr   <= '0;
      issued    <= '0;
      evaluated <= '0;
      pend      <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_addr <= clr_addr + IW'(1);
      end
      if (cmd.capture) begin
        hc <= '0;
      end
      if (cmd.hash_step) begin
        hc <= hc + HC_BITS'(1);
      end
      if (hash_last) begin
        rd_addr   <= rem_next;
        issued    <= '0;
        evaluated <= '0;
      end
      if (rd_en) begin
        rd_addr <= rd_addr_next;
        issued  <= issued + CW'(1);
      end
      if (ev_ok) begin
        evaluated <= evaluated + CW'(1);
      end
      pend <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= operation;
      key_r  <= key;
      val_r  <= value_wide[VALUE_BITS-1:0];
      key_sh <= HASH_BITS'(key);
      rem    <= '0;
    end
    if (cmd.hash_step) begin
      key_sh <= key_sh << HASH_CHUNK;
      rem    <= rem_next;
    end
    // The failure result is preset, so running out of slots needs no extra step.
    if (hash_last) begin
      res_status <= is_ins ? ST_FULL : ST_MISSING;
      res_value  <= '0;
      res_slot   <= '0;
    end
    if (rd_en) begin
      ev_addr <= rd_addr;
    end
    if (hit) begin
      res_status <= ST_DONE;
      res_slot   <= ev_wide[SLOT_BITS-1:0];
      res_value  <= is_look ? rd_val_wide[DATA_BITS-1:0] : '0;
    end
    if (cmd.load_out) begin
      status     <= res_status;
      value_out  <= res_value;
      slot_index <= res_slot;
    end
  end

  assign sts.clear_done = (clr_addr == LAST_SLOT);
  assign sts.hash_last  = (hc == HC_LAST);
  assign sts.op_valid   = is_ins || is_look || is_del;
  assign sts.decided    = hit || stop || exhaust;

`ifndef ASSERT_OFF
  a_issued_bound : assert property (@(posedge clk) disable iff (rst)
    issued <= SLOTS_C)
    else $error("more probe reads issued than there are slots");

  a_eval_behind : assert property (@(posedge clk) disable iff (rst)
    evaluated <= issued)
    else $error("a slot word was evaluated without having been read");

  a_no_collide : assert property (@(posedge clk) disable iff (rst)
    (we && rd_en) |-> (waddr != rd_addr))
    else $error("slot write and probe read address the same slot");
`endif

endmodule
`default_nettype wire

@@ design/lpht_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_ctrl
// Controller: clearing pass, item acceptance, home-slot division, probing
// and hand-over of the result to the output register.
// ----------------------------------------------------------------------------
module lpht_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  output lpht_pkg::cmd_t cmd,
  input  lpht_pkg::sts_t sts
);
  import lpht_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_PROBE = 5'b01000,
    S_HOLD  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        // An unused operation code goes straight to its preset result.
        if (sts.hash_last) begin
          state_next = sts.op_valid ? S_PROBE : S_HOLD;
        end
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        if (sts.decided) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!m_tvalid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_load_free : assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("result loaded over a word not yet taken");

  a_load_shown : assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> m_tvalid)
    else $error("loaded result not presented on the output");
`endif

endmodule
`default_nettype wire

@@ design/linear_probe_hash_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing: insert, lookup and delete
// with tombstones, home slot at key modulo the slot count.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake           Word
// s_*       in   s_tvalid/s_tready   operation, key, value
// m_*       out  m_tvalid/m_tready   status, value_out, slot_index
//
// After reset a clearing pass marks every slot empty, one slot a cycle;
// s_tready stays low meanwhile.
// An item goes through home-slot division of the key, then one read of the
// slot memory per slot probed (1 to TABLE_SLOTS); an unused operation skips
// the probing. The next item is accepted only once the result has been
// moved into the output register.
// A finished result waits in the output register while the next item is taken;
// a further result waits until that word is taken.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
  parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF,
  parameter int VALUE_BITS  = lpht_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // operation [1:0], key [32:2], value [64:33], zero fill [71:65]
  input  logic [lpht_pkg::S_DATA_BITS-1:0] s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // status [1:0], value_out [33:2], slot_index [38:34], zero fill [39]
  output logic [lpht_pkg::M_DATA_BITS-1:0] m_tdata
);
  import lpht_pkg::*;

  localparam int KEY_LO = OP_BITS;
  localparam int VAL_LO = OP_BITS + KEY_BITS;
  localparam int PAD_BITS = M_DATA_BITS - STAT_BITS - DATA_BITS - SLOT_BITS;

  cmd_t                 cmd;
  sts_t                 sts;
  logic [STAT_BITS-1:0] status;
  logic [DATA_BITS-1:0] value_out;
  logic [SLOT_BITS-1:0] slot_index;

  lpht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  lpht_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .operation  (s_tdata[OP_BITS-1:0]),
    .key        (s_tdata[KEY_LO +: KEY_BITS]),
    .value      (s_tdata[VAL_LO +: DATA_BITS]),
    .status     (status),
    .value_out  (value_out),
    .slot_index (slot_index)
  );

  assign m_tdata = {{PAD_BITS{1'b0}}, slot_index, value_out, status};

endmodule
`default_nettype wire

@@ tb/sv/tb_linear_probe_hash_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table
// Self-checking bench for the linear probing hash table. A directed opening
// covers collisions, wraparound, tombstones, duplicate keys, absent keys and
// the unused operation code. Random phases then push the table towards a
// chosen load, full included, while both stream sides idle at random. Every
// result word is compared with a local model of the slot table.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table;
  import lpht_pkg::*;

  localparam int SLOTS = TABLE_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OP_BITS-1:0]   op;
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] val;
    int unsigned          gap;
    bit                   drain;
  } table_op_t;

  typedef struct {
    logic [STAT_BITS-1:0] status;
    logic [DATA_BITS-1:0] value_out;
    logic [SLOT_BITS-1:0] slot;
  } table_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // operation [1:0], key [32:2], value [64:33], zero fill [71:65]
  logic [S_DATA_BITS-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // status [1:0], value_out [33:2], slot_index [38:34], zero fill [39]
  logic [M_DATA_BITS-1:0] m_tdata;

  // Local copy of the slot table.
  logic [KEY_BITS-1:0]  slot_keys [SLOTS];
  logic [DATA_BITS-1:0] slot_vals [SLOTS];
  logic [MARK_BITS-1:0] slot_marks[SLOTS];

  table_op_t    pending_ops[$];
  table_reply_t expected_replies[$];
  logic [KEY_BITS-1:0] live_keys[$];

  table_op_t   in_flight;
  int unsigned send_hold = 0;
  int unsigned stall_left = 0;
  bit          rx_calm = 1'b0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  linear_probe_hash_table i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic table_reply_t apply_table_op(input table_op_t w);
    table_reply_t r;
    int unsigned  pos;
    int unsigned  n;
    bit           hit;
    r.status    = ST_MISSING;
    r.value_out = '0;
    r.slot      = '0;
    pos = w.key % SLOTS;
    hit = 1'b0;
    if (w.op == OP_INSERT) begin
      r.status = ST_FULL;
      for (n = 0; n < SLOTS; n++) begin
        if (slot_marks[pos] != MARK_USED) begin
          slot_keys[pos]  = w.key;
          slot_vals[pos]  = w.val;
          slot_marks[pos] = MARK_USED;
          r.status = ST_DONE;
          r.slot   = pos[SLOT_BITS-1:0];
          break;
        end
        pos = (pos + 1) % SLOTS;
      end
    end else if (w.op == OP_LOOKUP || w.op == OP_DELETE) begin
      // Tombstones are stepped over; an empty slot ends the chain.
      for (n = 0; n < SLOTS; n++) begin
        if (slot_marks[pos] == MARK_EMPTY) break;
        if (slot_marks[pos] == MARK_USED && slot_keys[pos] == w.key) begin
          hit = 1'b1;
          break;
        end
        pos = (pos + 1) % SLOTS;
      end
      if (hit) begin
        r.status = ST_DONE;
        r.slot   = pos[SLOT_BITS-1:0];
        if (w.op == OP_LOOKUP) r.value_out = slot_vals[pos];
        else slot_marks[pos] = MARK_GONE;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (errors < 40)
      $display("%0t mismatch in %s: expected %0h, got %0h", $realtime, what, want, got);
    errors++;
  endtask

  // Queues one operation and keeps the list of live keys in step with it.
  task automatic queue_op(input logic [OP_BITS-1:0] op, input logic [KEY_BITS-1:0] key,
                          input logic [DATA_BITS-1:0] val, input int unsigned gap,
                          input bit drain);
    table_op_t w;
    int i;
    w.op = op;
    w.key = key;
    w.val = val;
    w.gap = gap;
    w.drain = drain;
    pending_ops.push_back(w);
    if (op == OP_INSERT && live_keys.size() < SLOTS) begin
      live_keys.push_back(key);
    end else if (op == OP_DELETE) begin
      for (i = 0; i < live_keys.size(); i++) begin
        if (live_keys[i] == key) begin
          live_keys.delete(i);
          break;
        end
      end
    end
  endtask

  function automatic logic [KEY_BITS-1:0] fresh_key(input bit cluster);
    logic [KEY_BITS-1:0] k;
    k = KEY_BITS'($urandom);
    if (cluster) k[SLOT_BITS-1:0] = SLOT_BITS'($urandom_range(0, 5));
    return k;
  endfunction

  function automatic logic [DATA_BITS-1:0] random_value();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    else if (r == 1) return '1;
    else return $urandom;
  endfunction

  function automatic logic [KEY_BITS-1:0] pick_live();
    return live_keys[$urandom_range(0, live_keys.size() - 1)];
  endfunction

  // Driver: a new word goes out once the previous one is taken and its gap
  // has run down. A draining word first waits for every outstanding result.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_hold <= 0;
    end else begin
      if (s_tvalid && s_tready)
        expected_replies.push_back(apply_table_op(in_flight));
      if (!(s_tvalid && !s_tready)) begin
        if (send_hold != 0) begin
          send_hold <= send_hold - 1;
          s_tvalid <= 1'b0;
        end else if (pending_ops.size() != 0 &&
                     !(pending_ops[0].drain && expected_replies.size() != 0)) begin
          in_flight <= pending_ops[0];
          s_tdata <= {{(S_DATA_BITS - OP_BITS - KEY_BITS - DATA_BITS){1'b0}},
                      pending_ops[0].val, pending_ops[0].key, pending_ops[0].op};
          s_tvalid <= 1'b1;
          void'(pending_ops.pop_front());
          send_hold <= (pending_ops.size() != 0) ? pending_ops[0].gap : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word and throttles m_tready.
  always @(posedge clk) begin : monitor
    table_reply_t want;
    int unsigned n;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("word with nothing pending", '0, m_tdata[31:0]);
        end else begin
          want = expected_replies.pop_front();
          if (m_tdata[1:0] !== want.status)
            report_mismatch("status", 32'(want.status), 32'(m_tdata[1:0]));
          if (m_tdata[33:2] !== want.value_out)
            report_mismatch("value_out", want.value_out, m_tdata[33:2]);
          if (m_tdata[38:34] !== want.slot)
            report_mismatch("slot_index", 32'(want.slot), 32'(m_tdata[38:34]));
        end
        if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
        n = rx_calm ? 0 : pick_gap();
        if (n != 0) begin
          m_tready <= 1'b0;
          stall_left <= n - 1;
        end else begin
          m_tready <= 1'b1;
        end
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        m_tready <= 1'b0;
      end else if (!rx_calm && $urandom_range(0, 19) == 0) begin
        m_tready <= 1'b0;
        stall_left <= pick_gap();
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_linear_probe_hash_table NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned phase_len;
    int unsigned target;
    int unsigned ins_w;
    int unsigned r;
    int unsigned i;
    bit first;
    bit calm;
    bit cluster;
    logic [OP_BITS-1:0] op;
    logic [KEY_BITS-1:0] key;
    for (i = 0; i < SLOTS; i++) begin
      slot_keys[i]  = '0;
      slot_vals[i]  = '0;
      slot_marks[i] = MARK_EMPTY;
    end

    // Extremes, a home-slot-0 cluster, tombstones, duplicates and wraparound.
    queue_op(OP_INSERT, 31'd0,          32'hFFFF_FFFF, 0, 1'b0);
    queue_op(OP_INSERT, 31'h7FFF_FFFF,  32'h0000_0000, 0, 1'b0);
    queue_op(OP_INSERT, 31'd32,         32'h0000_1234, 0, 1'b0);
    queue_op(OP_INSERT, 31'h7FFF_FFE0,  32'hA5A5_A5A5, 1, 1'b0);
    queue_op(OP_LOOKUP, 31'd32,         32'hFFFF_FFFF, 0, 1'b0);
    queue_op(OP_LOOKUP, 31'h7FFF_FFFF,  32'd0,         0, 1'b0);
    queue_op(OP_DELETE, 31'd32,         32'd0,         2, 1'b0);
    queue_op(OP_LOOKUP, 31'h7FFF_FFE0,  32'd0,         0, 1'b0);
    queue_op(OP_LOOKUP, 31'd32,         32'd0,         0, 1'b0);
    queue_op(OP_LOOKUP, 31'd64,         32'd0,         0, 1'b0);
    queue_op(OP_INSERT, 31'd64,         32'h5A5A_5A5A, 0, 1'b0);
    queue_op(OP_INSERT, 31'd0,          32'h1111_1111, 0, 1'b0);
    queue_op(OP_LOOKUP, 31'd0,          32'd0,         0, 1'b0);
    queue_op(OP_DELETE, 31'd0,          32'd0,         0, 1'b0);
    queue_op(OP_LOOKUP, 31'd0,          32'd0,         3, 1'b0);
    queue_op(OP_UNUSED, 31'h7FFF_FFFF,  32'hFFFF_FFFF, 0, 1'b0);
    queue_op(OP_DELETE, 31'h7FFF_FFFF,  32'd0,         0, 1'b0);
    queue_op(OP_INSERT, 31'd31,         32'h8000_0001, 0, 1'b0);
    queue_op(OP_INSERT, 31'd63,         32'h7FFF_FFFE, 0, 1'b0);
    queue_op(OP_LOOKUP, 31'd63,         32'd0,         0, 1'b0);
    queue_op(OP_DELETE, 31'd95,         32'd0,         0, 1'b0);
    queue_op(OP_UNUSED, 31'd0,          32'd0,         0, 1'b0);

    // Random phases, each steering the load towards its own target. The
    // first one fills the table so that full inserts and whole-table misses
    // are reached early.
    first = 1'b1;
    while (pending_ops.size() < 1150) begin
      phase_len = $urandom_range(40, 120);
      target = (first || $urandom_range(0, 3) == 0) ? SLOTS : $urandom_range(0, SLOTS - 1);
      calm = ($urandom_range(0, 3) == 0);
      cluster = ($urandom_range(0, 1) != 0);
      for (i = 0; i < phase_len; i++) begin
        r = $urandom_range(0, 99);
        ins_w = (live_keys.size() < target) ? 65 : 20;
        if (r < 2) begin
          op = OP_UNUSED;
          key = fresh_key(1'b0);
        end else if (r < 2 + ins_w) begin
          op = OP_INSERT;
          key = (live_keys.size() != 0 && $urandom_range(0, 9) == 0) ?
                pick_live() : fresh_key(cluster);
        end else begin
          op = $urandom_range(0, 1) ? OP_LOOKUP : OP_DELETE;
          key = (live_keys.size() != 0 && $urandom_range(0, 9) < 7) ?
                pick_live() : fresh_key(cluster);
        end
        queue_op(op, key, random_value(), calm ? 0 : pick_gap(),
                 (i == 0) && (first || $urandom_range(0, 2) == 0));
      end
      first = 1'b0;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (3 * (SLOTS + 7)) @(posedge clk);
    if (errors == 0) begin
      $display("tb_linear_probe_hash_table OK");
    end else begin
      $display("tb_linear_probe_hash_table NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/lpht_pkg.sv
design/lpht_ram.sv
design/lpht_datapath.sv
design/lpht_ctrl.sv
design/linear_probe_hash_table.sv
tb/sv/tb_linear_probe_hash_table.sv
